// File: hw/rtl/ack_retransmit_table_top_assert.svh
// assertion helpers
`ifndef ACK_RETRANSMIT_TABLE_TOP_ASSERT_SVH
`define ACK_RETRANSMIT_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ART_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ART_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ART_ASSERT(lbl, clk, rst_n, prop)
`define ART_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/art_pkg.sv
package art_pkg;
    localparam int TableDepthDefault = 16;
    localparam int MaxResults = 16;
    localparam logic [15:0] DelayReset = 16'd300;
    localparam logic [7:0] UnqueuedType = 8'd5;

    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_ACK    = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_PURGE  = 2'd3;

    localparam logic [2:0] RES_RECORDED  = 3'd0;
    localparam logic [2:0] RES_NOT_QUEUED = 3'd1;
    localparam logic [2:0] RES_FULL      = 3'd2;
    localparam logic [2:0] RES_ACKED     = 3'd3;
    localparam logic [2:0] RES_UNKNOWN   = 3'd4;
    localparam logic [2:0] RES_RETX      = 3'd5;
    localparam logic [2:0] RES_NONE_DUE  = 3'd6;
    localparam logic [2:0] RES_PURGED    = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] sequence_number;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [15:0] payload_handle;
        logic [7:0]  message_type;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] out_sequence;
        logic [31:0] out_address;
        logic [15:0] out_port;
        logic [15:0] out_handle;
        logic [4:0]  purged_count;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] handle;
        logic [31:0] sent;
    } t_entry;
endpackage

// File: hw/rtl/ack_retransmit_table_top.sv
// Table of sent messages awaiting acknowledgement.
// Input channel i_in_valid / o_in_stall carries one t_in_word; output
// channel o_out_valid / i_out_stall carries t_out_word results, the last
// one of each input flagged by last_result. Config: i_cfg_valid/o_cfg_ready
// writes retransmit_delay (reset 300) while the block is idle.
// Entries live in one memory in arrival order (a ring), oldest at the head.
// One item is in flight at a time; its last result is registered once the
// walk ends and the output register is free. Records, refused or not, do
// no walk. Ticks, ack misses and purges read one entry at a time through
// the single read port. An ack hit then moves each older entry up one
// position, toward the newer end, to close the gap.
// Each result waits in one output register; the walk pauses while a result
// is held and the next one is ready (a tick holds back each due entry until
// the next is found, so it knows which one is last).
// Reset (synchronous, active low) empties the table at once through the
// fill count; no clearing pass is needed. Stall is high whenever busy.
module ack_retransmit_table_top
    import art_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
`include "ack_retransmit_table_top_assert.svh"
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam bit TickCapped = (MaxResults < TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_PMOVE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   r_we;
    logic [AW-1:0] r_wa;
    t_entry r_wd;

    t_state r_st;
    t_in_word r_in;
    logic [15:0] r_delay;
    logic [AW-1:0] r_head;   // physical slot of oldest entry
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;    // logical position from newest
    logic [CW-1:0] r_wr;     // purge write position (from oldest)
    logic [CW-1:0] r_rdp;    // purge read position (from oldest)
    logic [CW-1:0] r_emitted;
    logic [4:0]  r_pcnt;
    logic r_ovalid;
    t_out_word r_out;
    t_entry r_hold;          // entry whose result is still to be sent

    // physical address of logical position p counted from oldest
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] p);
        logic [CW:0] s;
        s = {1'b0, p} + {{(CW+1-AW){1'b0}}, head};
        if (s >= (CW+1)'(TABLE_DEPTH)) s = s - (CW+1)'(TABLE_DEPTH);
        return s[AW-1:0];
    endfunction

    logic [CW-1:0] w_old_pos;   // oldest-based index of r_idx (newest-based)
    assign w_old_pos = r_cnt - 1'b1 - r_idx;

    logic out_free;
    assign out_free = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    logic [31:0] w_elapsed;
    assign w_elapsed = r_in.now_ms - r_rd.sent;

    logic w_match_ack, w_match_purge, w_due;
    assign w_match_purge = (r_rd.addr == r_in.dest_address) && (r_rd.port == r_in.dest_port);
    assign w_match_ack   = w_match_purge && (r_rd.seq == r_in.sequence_number);
    assign w_due         = w_elapsed > {16'd0, r_delay};

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_wa] <= r_wd;
        r_rd <= r_mem[r_st == S_PMOVE || r_in.action == ACT_PURGE ?
                      phys(r_head, r_rdp) : phys(r_head, w_old_pos)];
    end

    function automatic t_out_word mk(input logic [2:0] k, input t_entry e,
                                     input logic [4:0] c, input logic last);
        t_out_word o;
        o.result_kind  = k;
        o.out_sequence = e.seq;
        o.out_address  = e.addr;
        o.out_port     = e.port;
        o.out_handle   = e.handle;
        o.purged_count = c;
        o.last_result  = last;
        return o;
    endfunction

    t_entry w_zero;
    assign w_zero = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_delay <= DelayReset;
            r_head <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_we <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid) r_delay <= i_cfg_data;
                    if (i_in_valid) begin
                        r_in <= i_in_word;
                        r_idx <= '0;
                        r_rdp <= '0;
                        r_wr <= '0;
                        r_emitted <= '0;
                        r_pcnt <= '0;
                        if (i_in_word.action == ACT_RECORD) r_st <= S_DONE;
                        else if (r_cnt == '0) r_st <= S_DONE;
                        else r_st <= S_READ;
                    end
                end
                S_READ: r_st <= S_EVAL;   // read address issued this cycle
                S_EVAL: begin
                    unique case (r_in.action)
                        ACT_ACK: begin
                            if (w_match_ack) begin
                                r_hold <= r_rd;
                                r_st <= S_PMOVE;   // close gap: shift older up
                                r_rdp <= w_old_pos;
                                r_wr <= w_old_pos;
                            end else if (r_idx + 1'b1 == r_cnt) begin
                                r_st <= S_DONE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                                r_st <= S_READ;
                            end
                        end
                        ACT_TICK: begin
                            if (w_due && (!TickCapped || r_emitted < CW'(MaxResults))) begin
                                if (r_emitted == '0 || out_free) begin
                                    if (r_emitted != '0) begin
                                        r_out <= mk(RES_RETX, r_hold, 5'd0, 1'b0);
                                        r_ovalid <= 1'b1;
                                    end
                                    r_we <= 1'b1;
                                    r_wa <= phys(r_head, w_old_pos);
                                    r_wd <= '{seq: r_rd.seq, addr: r_rd.addr, port: r_rd.port,
                                              handle: r_rd.handle, sent: r_in.now_ms};
                                    r_hold <= r_rd;
                                    r_emitted <= r_emitted + 1'b1;
                                    if (r_idx + 1'b1 == r_cnt) r_st <= S_DONE;
                                    else begin
                                        r_idx <= r_idx + 1'b1;
                                        r_st <= S_READ;
                                    end
                                end
                            end else if (r_idx + 1'b1 == r_cnt) begin
                                r_st <= S_DONE;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                                r_st <= S_READ;
                            end
                        end
                        default: begin   // purge: compact from oldest
                            if (w_match_purge) begin
                                if (r_pcnt != 5'd31) r_pcnt <= r_pcnt + 1'b1;
                            end else begin
                                r_we <= 1'b1;
                                r_wa <= phys(r_head, r_wr);
                                r_wd <= r_rd;
                                r_wr <= r_wr + 1'b1;
                            end
                            if (r_rdp + 1'b1 == r_cnt) r_st <= S_DONE;
                            else begin
                                r_rdp <= r_rdp + 1'b1;
                                r_st <= S_READ;
                            end
                        end
                    endcase
                end
                S_PMOVE: begin
                    // ack removal: entries older than the hit move one up (newer)
                    // positions are oldest-based; r_rdp is the hole
                    if (r_wr == r_rdp) begin
                        if (r_rdp == '0) begin
                            if (out_free) begin
                                r_ovalid <= 1'b1;
                                r_out <= mk(RES_ACKED, r_hold, 5'd0, 1'b1);
                                r_head <= (r_head == AW'(TABLE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                                r_cnt <= r_cnt - 1'b1;
                                r_st <= S_IDLE;
                            end
                        end else begin
                            r_rdp <= r_rdp - 1'b1;   // issue read of older neighbor
                            r_wr <= r_rdp + 1'b1;
                        end
                    end else if (r_wr == r_rdp + CW'(2)) begin
                        r_wr <= r_rdp + 1'b1;        // read data lands next cycle
                    end else begin
                        r_we <= 1'b1;
                        r_wa <= phys(r_head, r_rdp + 1'b1);
                        r_wd <= r_rd;
                        r_wr <= r_rdp;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                        unique case (r_in.action)
                            ACT_RECORD: begin
                                if (r_in.message_type == UnqueuedType)
                                    r_out <= mk(RES_NOT_QUEUED, w_zero, 5'd0, 1'b1);
                                else if (r_cnt == CW'(TABLE_DEPTH))
                                    r_out <= mk(RES_FULL, w_zero, 5'd0, 1'b1);
                                else begin
                                    r_we <= 1'b1;
                                    r_wa <= phys(r_head, r_cnt);
                                    r_wd <= '{seq: r_in.sequence_number,
                                              addr: r_in.dest_address,
                                              port: r_in.dest_port,
                                              handle: r_in.payload_handle,
                                              sent: r_in.now_ms};
                                    r_cnt <= r_cnt + 1'b1;
                                    r_out <= mk(RES_RECORDED, w_zero, 5'd0, 1'b1);
                                end
                            end
                            ACT_ACK: r_out <= mk(RES_UNKNOWN, w_zero, 5'd0, 1'b1);
                            ACT_TICK: begin
                                if (r_emitted == '0)
                                    r_out <= mk(RES_NONE_DUE, w_zero, 5'd0, 1'b1);
                                else
                                    r_out <= mk(RES_RETX, r_hold, 5'd0, 1'b1);
                            end
                            default: begin
                                r_out <= mk(RES_PURGED, w_zero, r_pcnt, 1'b1);
                                r_cnt <= r_wr;
                            end
                        endcase
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `ART_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CW'(TABLE_DEPTH))
    `ART_ASSERT(a_busy_stall, i_clk, i_rst_n, (r_st != S_IDLE) |-> o_in_stall)
    `ART_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
    `ART_ASSERT(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready |-> (r_st == S_IDLE))
endmodule

// File: sim/tb_ack_retransmit_table_top.sv
`timescale 1ns / 100ps

module tb_ack_retransmit_table_top;
    import art_pkg::*;

    localparam int Depth = 16;
    localparam int WatchLimit = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [15:0] i_cfg_data;

    ack_retransmit_table_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow table, newest at index 0
    t_entry    tbl[$];
    logic [15:0] delay_ms;
    t_out_word pending_words[$];
    int        fails;
    int        send_idle;
    int        recv_idle;
    bit        hold_recv;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_word mk(logic [2:0] kind, t_entry e, logic [4:0] cnt);
        t_out_word w;
        w = '0;
        w.result_kind = kind;
        w.out_sequence = e.seq;
        w.out_address = e.addr;
        w.out_port = e.port;
        w.out_handle = e.handle;
        w.purged_count = cnt;
        return w;
    endfunction

    task automatic predict_table(input t_in_word w);
        t_entry e;
        t_entry z;
        int i;
        int cnt;
        bit hit;
        z = '0;
        case (w.action)
            ACT_RECORD: begin
                if (w.message_type == UnqueuedType) begin
                    pending_words.push_back(mk(RES_NOT_QUEUED, z, 0));
                end else if (tbl.size() >= Depth) begin
                    pending_words.push_back(mk(RES_FULL, z, 0));
                end else begin
                    e.seq = w.sequence_number;
                    e.addr = w.dest_address;
                    e.port = w.dest_port;
                    e.handle = w.payload_handle;
                    e.sent = w.now_ms;
                    tbl.push_front(e);
                    pending_words.push_back(mk(RES_RECORDED, z, 0));
                end
            end
            ACT_ACK: begin
                hit = 1'b0;
                for (i = 0; i < tbl.size(); i++) begin
                    if (!hit && tbl[i].seq == w.sequence_number &&
                        tbl[i].addr == w.dest_address && tbl[i].port == w.dest_port) begin
                        pending_words.push_back(mk(RES_ACKED, tbl[i], 0));
                        tbl.delete(i);
                        hit = 1'b1;
                    end
                end
                if (!hit) pending_words.push_back(mk(RES_UNKNOWN, z, 0));
            end
            ACT_TICK: begin
                cnt = 0;
                for (i = 0; i < tbl.size() && cnt < MaxResults; i++) begin
                    if (32'(w.now_ms - tbl[i].sent) > {16'd0, delay_ms}) begin
                        pending_words.push_back(mk(RES_RETX, tbl[i], 0));
                        tbl[i].sent = w.now_ms;
                        cnt++;
                    end
                end
                if (cnt == 0) pending_words.push_back(mk(RES_NONE_DUE, z, 0));
            end
            default: begin
                cnt = 0;
                i = 0;
                while (i < tbl.size()) begin
                    if (tbl[i].addr == w.dest_address && tbl[i].port == w.dest_port) begin
                        tbl.delete(i);
                        cnt++;
                    end else begin
                        i++;
                    end
                end
                pending_words.push_back(mk(RES_PURGED, z, (cnt > 31) ? 5'd31 : 5'(cnt)));
            end
        endcase
        pending_words[pending_words.size() - 1].last_result = 1'b1;
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word %h", o_out_word);
                fails++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_out_word.result_kind !== exp_w.result_kind) begin
                    $error("result_kind exp %0d got %0d", exp_w.result_kind,
                           o_out_word.result_kind);
                    fails++;
                end
                if (o_out_word.out_sequence !== exp_w.out_sequence) begin
                    $error("out_sequence exp %h got %h", exp_w.out_sequence,
                           o_out_word.out_sequence);
                    fails++;
                end
                if (o_out_word.out_address !== exp_w.out_address) begin
                    $error("out_address exp %h got %h", exp_w.out_address,
                           o_out_word.out_address);
                    fails++;
                end
                if (o_out_word.out_port !== exp_w.out_port) begin
                    $error("out_port exp %h got %h", exp_w.out_port, o_out_word.out_port);
                    fails++;
                end
                if (o_out_word.out_handle !== exp_w.out_handle) begin
                    $error("out_handle exp %h got %h", exp_w.out_handle,
                           o_out_word.out_handle);
                    fails++;
                end
                if (o_out_word.purged_count !== exp_w.purged_count) begin
                    $error("purged_count exp %0d got %0d", exp_w.purged_count,
                           o_out_word.purged_count);
                    fails++;
                end
                if (o_out_word.last_result !== exp_w.last_result) begin
                    $error("last_result exp %0d got %0d", exp_w.last_result,
                           o_out_word.last_result);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_table(w);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [15:0] v);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        delay_ms = v;
    endtask

    function automatic t_in_word mk_in(logic [1:0] act, logic [31:0] seq,
                                       logic [31:0] addr, logic [15:0] port,
                                       logic [15:0] hnd, logic [7:0] mt,
                                       logic [31:0] now);
        t_in_word w;
        w.action = act;
        w.sequence_number = seq;
        w.dest_address = addr;
        w.dest_port = port;
        w.payload_handle = hnd;
        w.message_type = mt;
        w.now_ms = now;
        return w;
    endfunction

    function automatic t_in_word rand_word(input int mode);
        t_in_word w;
        int pick;
        w = mk_in(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom),
                  16'($urandom), 8'($urandom), $urandom);
        if (mode == 0) begin
            // small pool of peers so acks and purges hit
            w.dest_address = {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0A00_0000} |
                             32'($urandom_range(3));
            w.dest_port = 16'($urandom_range(2)) | ($urandom_range(1) ? 16'hFFF0 : 16'h0);
            w.sequence_number = 32'($urandom_range(7)) | ($urandom_range(1) ? 32'hFFFF_FF00 : 0);
            w.now_ms = 32'($urandom_range(1200)) | ($urandom_range(3) == 0 ? 32'hFFFF_F000 : 0);
            pick = $urandom_range(9);
            w.action = (pick < 4) ? ACT_RECORD : (pick < 6) ? ACT_ACK :
                       (pick < 9) ? ACT_TICK : ACT_PURGE;
            if ($urandom_range(15) == 0) w.message_type = UnqueuedType;
        end
        return w;
    endfunction

    typedef struct {
        t_in_word  w;
        bit        known;
        t_out_word res;
    } t_row;

    initial begin
        t_row rows[$];
        t_row r;
        t_out_word z;
        int i;
        int ph;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        fails = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_recv = 1'b0;
        delay_ms = DelayReset;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z = '0;
        z.last_result = 1'b1;
        r.known = 1'b1;
        r.res = z;
        r.res.result_kind = RES_NONE_DUE;
        r.w = mk_in(ACT_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        rows.push_back(r);
        r.res.result_kind = RES_UNKNOWN;
        r.w = mk_in(ACT_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0);
        rows.push_back(r);
        r.res.result_kind = RES_PURGED;
        r.w = mk_in(ACT_PURGE, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.res.result_kind = RES_NOT_QUEUED;
        r.w = mk_in(ACT_RECORD, 1, 2, 3, 4, UnqueuedType, 0);
        rows.push_back(r);
        r.res.result_kind = RES_RECORDED;
        r.w = mk_in(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                    8'hFF, 32'hFFFF_FFFF);
        rows.push_back(r);
        r.w = mk_in(ACT_RECORD, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.known = 1'b0;
        r.w = mk_in(ACT_TICK, 0, 0, 0, 0, 0, 300);
        rows.push_back(r);
        r.w = mk_in(ACT_TICK, 0, 0, 0, 0, 0, 301);
        rows.push_back(r);
        r.w = mk_in(ACT_ACK, 0, 0, 0, 0, 0, 0);
        rows.push_back(r);
        for (i = 0; i < 16; i++) begin
            r.w = mk_in(ACT_RECORD, i, 32'h0A00_0001, 16'(i % 2), 16'(i), 8'(i), 32'(i));
            rows.push_back(r);
        end
        r.known = 1'b1;
        r.res.result_kind = RES_FULL;
        r.w = mk_in(ACT_RECORD, 99, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.known = 1'b0;
        r.w = mk_in(ACT_TICK, 0, 0, 0, 0, 0, 32'h8000_0000);
        rows.push_back(r);
        r.w = mk_in(ACT_PURGE, 0, 32'h0A00_0001, 16'd1, 0, 0, 0);
        rows.push_back(r);
        r.w = mk_in(ACT_PURGE, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0);
        rows.push_back(r);

        send_idle = 6;
        recv_idle = 55;
        foreach (rows[j]) begin
            if (rows[j].known) begin
                while (pending_words.size() != 0) @(posedge i_clk);
            end
            send_word(rows[j].w);
            if (rows[j].known && pending_words[pending_words.size() - 1] !== rows[j].res) begin
                $error("table row %0d exp %h pred %h", j, rows[j].res,
                       pending_words[pending_words.size() - 1]);
                fails++;
            end
        end

        write_delay(16'd0);
        for (i = 0; i < 40; i++) send_word(rand_word(i % 8 == 0));

        // long receiver hold-off so the table backs up
        fork
            begin
                hold_recv = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (i = 0; i < 20; i++) send_word(rand_word(0));
        join

        for (ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 55 : 0;
            recv_idle = (ph == 0) ? 6 : 0;
            write_delay((ph == 0) ? 16'hFFFF : (ph == 1) ? 16'd1 : DelayReset);
            for (i = 0; i < 47; i++) send_word(rand_word(i % 10 == 0));
        end

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/art_pkg.sv
hw/rtl/ack_retransmit_table_top.sv
sim/tb_ack_retransmit_table_top.sv
